@@ rtl/core/pbm_pkg.sv @@
// Shared types for the pixel blend mode unit.
// Depends on nothing; used by the top level and the divider step.
`default_nettype none

package pbm_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned NUM_W = 18;
  localparam int unsigned DEN_W = 9;

  localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_SUBTRACT = 3'd1,
    MODE_MULTIPLY = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_LIGHTEN  = 3'd4,
    MODE_DARKEN   = 3'd5,
    MODE_DODGE    = 3'd6,
    MODE_BURN     = 3'd7
  } mode_t;

  // How the last stage turns the quotient into the pixel.
  typedef enum logic [1:0] {
    RES_DIRECT = 2'd0,
    RES_QUO    = 2'd1,
    RES_INV    = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [PIX_W-1:0] quo;
    logic             sat;
    res_kind_t        kind;
    logic [PIX_W-1:0] alt;
    logic             last;
  } div_pay_t;

endpackage

`default_nettype wire

@@ rtl/core/pbm_div_step.sv @@
// One pipeline slice of the restoring divider: two quotient bits.
// Depends on pbm_pkg for the payload struct.
`default_nettype none

module pbm_div_step #(
  parameter int unsigned BIT_HI = 7
) (
  input  var pbm_pkg::div_pay_t pay_in,
  output pbm_pkg::div_pay_t     pay_out
);

  logic [pbm_pkg::NUM_W-1:0] dsh_hi;
  logic [pbm_pkg::NUM_W-1:0] dsh_lo;
  logic [pbm_pkg::NUM_W-1:0] rem_mid;

  assign dsh_hi = pbm_pkg::NUM_W'(pay_in.den) << BIT_HI;
  assign dsh_lo = pbm_pkg::NUM_W'(pay_in.den) << (BIT_HI - 1);

  always_comb begin
    pay_out = pay_in;
    rem_mid = pay_in.rem;
    if (pay_in.rem >= dsh_hi) begin
      rem_mid = pay_in.rem - dsh_hi;
      pay_out.quo[BIT_HI] = 1'b1;
    end
    pay_out.rem = rem_mid;
    if (rem_mid >= dsh_lo) begin
      pay_out.rem = rem_mid - dsh_lo;
      pay_out.quo[BIT_HI-1] = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pixel_blend_mode_unit_top.sv @@
// Takes one pixel per clock while the output is not stalled (out_ready high).
// Stage 1 forms the multiply and the rounded dividend, stages 2 to 5 run a
// restoring divider two quotient bits at a time, stage 6 maps the result.
// Each stage holds its own valid bit, so a stall only backs up full stages.
// Synchronous active-low reset empties the pipeline and sets the mode to add.
`default_nettype none

module pixel_blend_mode_unit_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_blend_mode,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_pixel_a,
  input  wire logic [7:0] in_pixel_b,
  input  wire logic       in_last_pixel,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_blended,
  output logic            out_last_out
);

  pbm_pkg::mode_t    mode_r;
  logic [6:1]        valid_r;
  logic [6:1]        valid_nxt;
  logic [7:1]        adv;
  pbm_pkg::div_pay_t pay_r     [1:5];
  pbm_pkg::div_pay_t front_nxt;
  pbm_pkg::div_pay_t pay_nxt   [2:5];
  pbm_pkg::div_pay_t step_out  [2:5];
  logic [7:0]        blended_r;
  logic [7:0]        blended_nxt;
  logic              last_r;

  // Operands of the front-end multiply and dividend shaping.
  logic [7:0]        mul_a;
  logic [7:0]        mul_b;
  logic [15:0]       prod;
  logic              quad;
  logic [7:0]        addend;
  logic [8:0]        sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pbm_pkg::MODE_ADD;
    end else if (cfg_valid) begin
      mode_r <= pbm_pkg::mode_t'(cfg_blend_mode);
    end
  end

  // A stage loads when it is empty or its contents move on this cycle.
  always_comb begin
    adv[7] = out_ready;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
    valid_nxt[1] = adv[1] ? in_valid : valid_r[1];
    for (int k = 2; k <= 6; k++) begin
      valid_nxt[k] = adv[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  assign in_ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Front end: every rounded division becomes floor(N / D) with N = 2x + y,
  // D = 2y, so one divider serves multiply, overlay, dodge and burn.
  assign sum  = {1'b0, in_pixel_a} + {1'b0, in_pixel_b};
  assign prod = mul_a * mul_b;

  always_comb begin
    mul_a          = in_pixel_a;
    mul_b          = in_pixel_b;
    quad           = 1'b0;
    addend         = pbm_pkg::PIX_FULL;
    front_nxt      = '0;
    front_nxt.den  = {pbm_pkg::PIX_FULL, 1'b0};
    front_nxt.last = in_last_pixel;
    front_nxt.kind = pbm_pkg::RES_DIRECT;
    unique case (mode_r)
      pbm_pkg::MODE_ADD: begin
        front_nxt.alt = sum[8] ? pbm_pkg::PIX_FULL : sum[7:0];
      end
      pbm_pkg::MODE_SUBTRACT: begin
        front_nxt.alt = (in_pixel_a > in_pixel_b) ? (in_pixel_a - in_pixel_b)
                                                  : pbm_pkg::PIX_ZERO;
      end
      pbm_pkg::MODE_MULTIPLY: begin
        front_nxt.kind = pbm_pkg::RES_QUO;
      end
      pbm_pkg::MODE_OVERLAY: begin
        quad = 1'b1;
        if (in_pixel_b[7]) begin
          mul_a = ~in_pixel_a;
          mul_b = ~in_pixel_b;
          front_nxt.kind = pbm_pkg::RES_INV;
        end else begin
          front_nxt.kind = pbm_pkg::RES_QUO;
        end
      end
      pbm_pkg::MODE_LIGHTEN: begin
        front_nxt.alt = (in_pixel_a > in_pixel_b) ? in_pixel_a : in_pixel_b;
      end
      pbm_pkg::MODE_DARKEN: begin
        front_nxt.alt = (in_pixel_a < in_pixel_b) ? in_pixel_a : in_pixel_b;
      end
      pbm_pkg::MODE_DODGE: begin
        mul_a  = pbm_pkg::PIX_FULL;
        addend = ~in_pixel_a;
        if (in_pixel_a == pbm_pkg::PIX_FULL) begin
          front_nxt.alt = pbm_pkg::PIX_FULL;
        end else begin
          front_nxt.den  = {~in_pixel_a, 1'b0};
          front_nxt.kind = pbm_pkg::RES_QUO;
        end
      end
      pbm_pkg::MODE_BURN: begin
        mul_a  = pbm_pkg::PIX_FULL;
        mul_b  = ~in_pixel_b;
        addend = in_pixel_a;
        if (in_pixel_a == pbm_pkg::PIX_ZERO) begin
          front_nxt.alt = pbm_pkg::PIX_ZERO;
        end else begin
          front_nxt.den  = {in_pixel_a, 1'b0};
          front_nxt.kind = pbm_pkg::RES_INV;
        end
      end
      default: begin
        front_nxt.alt = pbm_pkg::PIX_ZERO;
      end
    endcase
    front_nxt.rem = (quad ? {prod, 2'b00} : {1'b0, prod, 1'b0})
                    + pbm_pkg::NUM_W'(addend);
  end

  for (genvar k = 2; k <= 5; k++) begin : g_div
    pbm_div_step #(.BIT_HI(11 - 2 * k)) u_step (
      .pay_in  (pay_r[k-1]),
      .pay_out (step_out[k])
    );
  end

  // The quotient only fits in eight bits when N < 256 * D; otherwise it
  // saturates, which the first divider stage detects.
  always_comb begin
    for (int k = 2; k <= 5; k++) begin
      pay_nxt[k] = step_out[k];
    end
    pay_nxt[2].sat = (pay_r[1].rem >= pbm_pkg::NUM_W'({pay_r[1].den, 8'h00}));
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pay_r[1] <= front_nxt;
    end
    for (int k = 2; k <= 5; k++) begin
      if (adv[k]) begin
        pay_r[k] <= pay_nxt[k];
      end
    end
  end

  always_comb begin
    unique case (pay_r[5].kind)
      pbm_pkg::RES_DIRECT: blended_nxt = pay_r[5].alt;
      pbm_pkg::RES_QUO:    blended_nxt = pay_r[5].sat ? pbm_pkg::PIX_FULL : pay_r[5].quo;
      pbm_pkg::RES_INV:    blended_nxt = pay_r[5].sat ? pbm_pkg::PIX_ZERO : ~pay_r[5].quo;
      default:             blended_nxt = pay_r[5].alt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      blended_r <= blended_nxt;
      last_r    <= pay_r[5].last;
    end
  end

  assign out_valid    = valid_r[6];
  assign out_blended  = blended_r;
  assign out_last_out = last_r;

endmodule

`default_nettype wire

@@ rtl/core/pbm_checker.sv @@
// Port-level checks for the pixel blend mode unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module pbm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_blended,
  input wire logic       out_last_out
);

  // Reset must leave the pipeline empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A free output means no stage is stalled, so a request is always taken.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_blended) && $stable(out_last_out))
    else $error("result changed while stalled");

endmodule

bind pixel_blend_mode_unit_top pbm_checker u_pbm_checker (.*);

`default_nettype wire

@@ tb/blend_result_monitor.sv @@
// Monitor for the pixel blend mode unit: tracks the mode register, predicts each
// blended pixel from the accepted requests and checks the results in order.
// Depends on pbm_pkg for the mode codes and pixel limits.
`timescale 1ns / 1ps

module blend_result_monitor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [2:0] cfg_blend_mode,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_pixel_a,
  input  wire logic [7:0] in_pixel_b,
  input  wire logic       in_last_pixel,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_blended,
  input  wire logic       out_last_out,
  output int              fail_count,
  output int              pending_count,
  output int              checked_count
);

  localparam int unsigned FULL = pbm_pkg::PIX_FULL;

  typedef struct {
    logic [7:0] blended;
    logic       last;
  } blended_pixel_t;

  blended_pixel_t pending_pixels[$];
  pbm_pkg::mode_t active_mode;

  // floor(num/den + 1/2) without leaving integer arithmetic.
  function automatic int unsigned div_half_up(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [7:0] blend_pixel(pbm_pkg::mode_t mode, logic [7:0] a,
                                             logic [7:0] b);
    int unsigned ua;
    int unsigned ub;
    int unsigned q;
    ua = a;
    ub = b;
    case (mode)
      pbm_pkg::MODE_ADD:      q = (ua + ub > FULL) ? FULL : ua + ub;
      pbm_pkg::MODE_SUBTRACT: q = (ua > ub) ? ua - ub : 0;
      pbm_pkg::MODE_MULTIPLY: q = div_half_up(ua * ub, FULL);
      pbm_pkg::MODE_OVERLAY: begin
        if (2 * ub <= FULL)
          q = div_half_up(2 * ua * ub, FULL);
        else
          q = FULL - div_half_up(2 * (FULL - ua) * (FULL - ub), FULL);
      end
      pbm_pkg::MODE_LIGHTEN:  q = (ua > ub) ? ua : ub;
      pbm_pkg::MODE_DARKEN:   q = (ua < ub) ? ua : ub;
      pbm_pkg::MODE_DODGE: begin
        if (ua == FULL) begin
          q = FULL;
        end else begin
          q = div_half_up(FULL * ub, FULL - ua);
          if (q > FULL) q = FULL;
        end
      end
      default: begin
        if (ua == 0) begin
          q = 0;
        end else begin
          q = div_half_up(FULL * (FULL - ub), ua);
          q = (q > FULL) ? 0 : FULL - q;
        end
      end
    endcase
    return q[7:0];
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    active_mode   = pbm_pkg::MODE_ADD;
  end

  always @(posedge clk) begin
    blended_pixel_t want;
    if (!rst_n) begin
      active_mode = pbm_pkg::MODE_ADD;
    end else begin
      if (cfg_valid && cfg_ready)
        active_mode = pbm_pkg::mode_t'(cfg_blend_mode);
      if (in_valid && in_ready) begin
        want.blended = blend_pixel(active_mode, in_pixel_a, in_pixel_b);
        want.last    = in_last_pixel;
        pending_pixels.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("result with no request outstanding: blended %0d, last_out %0d",
                 out_blended, out_last_out);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          checked_count++;
          if (out_blended !== want.blended) begin
            $error("blended mismatch: expected %0d, actual %0d", want.blended, out_blended);
            fail_count++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out mismatch: expected %0d, actual %0d", want.last, out_last_out);
            fail_count++;
          end
        end
      end
    end
    pending_count = pending_pixels.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the pixel blend mode unit testbench: clock, reset, mode writes and pixel
// stimulus with random back-pressure. Depends on pbm_pkg, the block and blend_result_monitor.
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 14;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_blend_mode;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_pixel_a;
  logic [7:0] in_pixel_b;
  logic       in_last_pixel;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_blended;
  logic       out_last_out;

  int fail_count;
  int pending_count;
  int checked_count;
  int idle_pct;
  int stall_left;
  int quiet_cycles;
  int pixels_sent;
  int mode_writes;

  pixel_blend_mode_unit_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_blend_mode (cfg_blend_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_a     (in_pixel_a),
    .in_pixel_b     (in_pixel_b),
    .in_last_pixel  (in_last_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blended    (out_blended),
    .out_last_out   (out_last_out)
  );

  blend_result_monitor monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_blend_mode (cfg_blend_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_a     (in_pixel_a),
    .in_pixel_b     (in_pixel_b),
    .in_last_pixel  (in_last_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blended    (out_blended),
    .out_last_out   (out_last_out),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure in bursts, as often as the current phase allows.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Ends the run if no channel moves a request for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Returns at the rising edge where the pixel pair is taken; valid stays high
  // until the next call or a mode write decides what happens at the falling edge.
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic last);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_a    <= a;
    in_pixel_b    <= b;
    in_last_pixel <= last;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // The mode changes only once every outstanding pixel has come back.
  task automatic write_mode(input pbm_pkg::mode_t mode);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_blend_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // Mostly uniform, with a share of the values where the blend formulas turn.
  function automatic logic [7:0] random_component();
    case ($urandom_range(0, 15))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'($urandom_range(0, 1));
      5: return 8'($urandom_range(254, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int phase_items;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_blend_mode = pbm_pkg::MODE_ADD;
    in_valid       = 1'b0;
    in_pixel_a     = '0;
    in_pixel_b     = '0;
    in_last_pixel  = 1'b0;
    out_ready      = 1'b1;
    stall_left     = 0;
    quiet_cycles   = 0;
    pixels_sent    = 0;
    mode_writes    = 0;
    idle_pct       = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: both extremes in every mode, then the case that matters for it.
    idle_pct = 15;
    for (int m = pbm_pkg::MODE_ADD; m <= pbm_pkg::MODE_BURN; m++) begin
      write_mode(pbm_pkg::mode_t'(m));
      send_pixel(8'd0, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 1'b0);
      case (pbm_pkg::mode_t'(m))
        pbm_pkg::MODE_ADD:      send_pixel(8'd200, 8'd100, 1'b1);  // saturates
        pbm_pkg::MODE_SUBTRACT: send_pixel(8'd100, 8'd200, 1'b1);  // clamps at zero
        pbm_pkg::MODE_MULTIPLY: send_pixel(8'd128, 8'd128, 1'b1);
        pbm_pkg::MODE_OVERLAY:  send_pixel(8'd100, 8'd128, 1'b1);  // first b on the upper branch
        pbm_pkg::MODE_LIGHTEN:  send_pixel(8'd77, 8'd78, 1'b1);
        pbm_pkg::MODE_DARKEN:   send_pixel(8'd78, 8'd77, 1'b1);
        pbm_pkg::MODE_DODGE:    send_pixel(8'd200, 8'd200, 1'b1);  // quotient overflows
        default:                send_pixel(8'd10, 8'd10, 1'b1);    // quotient underflows
      endcase
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      // The closing phase runs with no idling on either side.
      if (p == RANDOM_PHASES - 1) idle_pct = 0;
      write_mode(pbm_pkg::mode_t'($urandom_range(pbm_pkg::MODE_ADD, pbm_pkg::MODE_BURN)));
      phase_items = $urandom_range(80, 112);
      for (int i = 0; i < phase_items; i++)
        send_pixel(random_component(), random_component(), ($urandom_range(0, 15) == 0));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("Sent %0d pixel pairs over %0d mode writes covering all eight blend modes.",
             pixels_sent, mode_writes);
    $display("Compared %0d blended results, %0d mismatches.", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pbm_pkg.sv
rtl/core/pbm_div_step.sv
rtl/core/pixel_blend_mode_unit_top.sv
rtl/core/pbm_checker.sv
tb/blend_result_monitor.sv
tb/testbench.sv
